/* design/gbmf_pkg.sv */
package gbmf_pkg;

	// Geometry
	localparam int MAX_WIDTH    = 2048;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
	localparam int PIX_W        = 8;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

	localparam logic [COL_W-1:0] WLAST_RESET = 11'd639;
	localparam logic [ROW_W-1:0] HLAST_RESET = 12'd479;

	// Reciprocal multipliers: floor(s/3) for s <= 765, floor(s/9) for s <= 2295
	localparam logic [9:0]  RECIP3 = 10'd683;
	localparam int          RECIP3_SH = 11;
	localparam logic [12:0] RECIP9 = 13'd7282;
	localparam int          RECIP9_SH = 16;

	// Result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// Result kinds released by one pixel
	localparam int KIND_DELAYED = 0;
	localparam int KIND_ROW_END = 1;
	localparam int KIND_OWN     = 2;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [COL_W-1:0] out_col;
		logic [ROW_W-1:0] out_row;
		logic [PIX_W-1:0] filtered;
		logic             last_in_run;
	} result_t;

endpackage

/* design/gray_box_mean_filter_3x3.sv */
// Gray 3x3 box mean filter over an RGB pixel stream.
// pixel channel: valid/ready beats of (red, green, blue) in raster order.
// result channel: valid/ready beats of (out_col, out_row, filtered, last_in_run);
//   each pixel releases zero to three results, the final one marked last_in_run.
// cfg port: cfg_we with cfg_index 0 (image width) or 1 (image height); a write
//   restarts the frame. Write only while no results are pending.
// Pipeline: a pixel's results pass the line buffer read, the window sum and the
//   divide by nine, then are queued.
// Throughput: one pixel per cycle while result_ready stays high and each pixel
//   releases at most one result; the result port sends one beat per cycle, so
//   in the last row (two results per pixel) and at row ends input is slowed to match.
// The two line buffers are 2048 x 8 single-write memories, read into registers as
//   the pixel is taken; a column is rewritten the cycle after its read.
// Reset: counters, window and result queue clear, width 640, height 480. The
//   line buffers are not cleared; their stale contents never reach a result.
// Stall: if result_ready is low, results wait in an 8-entry queue; pixel_ready
//   drops once the queue plus the two pipeline stages could fill it.
module gray_box_mean_filter_3x3 import gbmf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pixel_valid,
	output logic                  pixel_ready,
	input  pixel_t                pixel,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [PIX_W-1:0] val_a;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] gray;
		logic [2:0]       mask;
	} entry_t;

	// Line buffers
	logic [PIX_W-1:0] line_above     [MAX_WIDTH];
	logic [PIX_W-1:0] line_two_above [MAX_WIDTH];

	logic [COL_W-1:0] wlast_q;
	logic [ROW_W-1:0] hlast_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [PIX_W-1:0] window_q [6];

	logic             pixel_accept;
	logic             restart;
	logic [9:0]       rgb_sum;
	logic [19:0]      gray_prod;
	logic [PIX_W-1:0] gray_in;

	// Stage 1
	logic             v_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic [PIX_W-1:0] gray_s1;
	logic [PIX_W-1:0] top_s1;
	logic [PIX_W-1:0] mid_s1;
	logic [2:0]       mask_s1;
	logic             interior_s1;
	logic [11:0]      win_sum;

	// Stage 2
	logic             v_s2;
	logic [COL_W-1:0] col_s2;
	logic [ROW_W-1:0] row_s2;
	logic [PIX_W-1:0] gray_s2;
	logic [PIX_W-1:0] mid_s2;
	logic [PIX_W-1:0] border_s2;
	logic [2:0]       mask_s2;
	logic             interior_s2;
	logic [11:0]      sum_s2;
	logic [24:0]      mean_prod;
	logic [PIX_W-1:0] val_a;

	// Result queue
	entry_t              fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]  wr_ptr_q;
	logic [FIFO_AW-1:0]  rd_ptr_q;
	logic [FIFO_AW:0]    count_q;
	logic [2:0]          done_q;
	logic                push;
	logic                pop;
	logic                beat_out;
	entry_t              head;
	logic [2:0]          remain;
	logic [2:0]          sel;
	logic [FIFO_AW:0]    occupancy;

	assign pixel_accept = pixel_valid && pixel_ready;
	assign restart      = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

	// Credit check: queue entries plus pixels still in the pipeline
	assign occupancy   = count_q + {{FIFO_AW{1'b0}}, v_s1} + {{FIFO_AW{1'b0}}, v_s2};
	assign pixel_ready = occupancy < (FIFO_AW+1)'(FIFO_DEPTH);

	// Configuration, clamped on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= WLAST_RESET;
			hlast_q <= HLAST_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH: begin
					if (cfg_data[11:0] < 12'd3)
						wlast_q <= COL_W'(2);
					else if (cfg_data[11:0] > 12'(MAX_WIDTH))
						wlast_q <= COL_W'(MAX_WIDTH - 1);
					else
						wlast_q <= COL_W'(cfg_data[11:0] - 12'd1);
				end
				REG_HEIGHT: begin
					if (cfg_data < 13'd3)
						hlast_q <= ROW_W'(2);
					else if (cfg_data > 13'(HEIGHT_LIMIT))
						hlast_q <= ROW_W'(HEIGHT_LIMIT - 1);
					else
						hlast_q <= ROW_W'(cfg_data - 13'd1);
				end
				default: ;
			endcase
		end
	end

	// Gray conversion: floor(sum/3) by reciprocal
	assign rgb_sum   = {2'b0, pixel.red} + {2'b0, pixel.green} + {2'b0, pixel.blue};
	assign gray_prod = 20'(rgb_sum) * 20'(RECIP3);
	assign gray_in   = gray_prod[RECIP3_SH +: PIX_W];

	// Position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pixel_accept) begin
			if (col_q == wlast_q) begin
				col_q <= '0;
				row_q <= (row_q == hlast_q) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Line buffer read, registered
	always_ff @(posedge clk) begin
		if (pixel_accept) begin
			top_s1 <= line_two_above[col_q];
			mid_s1 <= line_above[col_q];
		end
	end

	// Line buffer write-back of the column just read
	always_ff @(posedge clk) begin
		if (v_s1) begin
			line_two_above[col_s1] <= mid_s1;
			line_above[col_s1]     <= gray_s1;
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= pixel_accept;
	end

	// Stage 1 payload and release flags
	always_ff @(posedge clk) begin
		if (pixel_accept) begin
			col_s1      <= col_q;
			row_s1      <= row_q;
			gray_s1     <= gray_in;
			mask_s1[KIND_DELAYED] <= (row_q != '0) && (col_q != '0);
			mask_s1[KIND_ROW_END] <= (row_q != '0) && (col_q == wlast_q);
			mask_s1[KIND_OWN]     <= (row_q == hlast_q);
			interior_s1 <= (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2));
		end
	end

	// Nine-term window sum
	assign win_sum = 12'(top_s1) + 12'(mid_s1) + 12'(gray_s1)
	               + 12'(window_q[0]) + 12'(window_q[1]) + 12'(window_q[2])
	               + 12'(window_q[3]) + 12'(window_q[4]) + 12'(window_q[5]);

	// Window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				window_q[i] <= '0;
		end else if (restart) begin
			for (int i = 0; i < 6; i++)
				window_q[i] <= '0;
		end else if (v_s1) begin
			window_q[3] <= window_q[0];
			window_q[4] <= window_q[1];
			window_q[5] <= window_q[2];
			window_q[0] <= top_s1;
			window_q[1] <= mid_s1;
			window_q[2] <= gray_s1;
		end
	end

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (v_s1) begin
			col_s2      <= col_s1;
			row_s2      <= row_s1;
			gray_s2     <= gray_s1;
			mid_s2      <= mid_s1;
			border_s2   <= window_q[1];
			mask_s2     <= mask_s1;
			interior_s2 <= interior_s1;
			sum_s2      <= win_sum;
		end
	end

	// Divide by nine by reciprocal; border pixels pass their own gray value
	assign mean_prod = 25'(sum_s2) * 25'(RECIP9);
	assign val_a     = interior_s2 ? mean_prod[RECIP9_SH +: PIX_W] : border_s2;
	assign push      = v_s2 && (mask_s2 != 3'b000);

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{col: col_s2, row: row_s2, val_a: val_a,
			                      mid: mid_s2, gray: gray_s2, mask: mask_s2};
		end
	end

	// Result serialiser over the head entry
	assign head         = fifo_q[rd_ptr_q];
	assign result_valid = (count_q != '0);
	assign remain       = head.mask & ~done_q;
	assign sel          = remain & (~remain + 3'd1);
	assign beat_out     = result_valid && result_ready;
	assign pop          = beat_out && ((remain & ~sel) == 3'b000);

	always_comb begin
		result.last_in_run = ((remain & ~sel) == 3'b000);
		if (sel[KIND_DELAYED]) begin
			result.out_col  = head.col - 1'b1;
			result.out_row  = head.row - 1'b1;
			result.filtered = head.val_a;
		end else if (sel[KIND_ROW_END]) begin
			result.out_col  = head.col;
			result.out_row  = head.row - 1'b1;
			result.filtered = head.mid;
		end else begin
			result.out_col  = head.col;
			result.out_row  = head.row;
			result.filtered = head.gray;
		end
	end

	// Queue pointers and per-entry progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			done_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
				done_q   <= '0;
			end else if (beat_out) begin
				done_q   <= done_q | sel;
			end
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* design/gbmf_checker.sv */
module gbmf_checker import gbmf_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  result_valid,
	input logic                  result_ready,
	input result_t               result
);

	// A stalled result beat is held
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat dropped or changed while stalled");

	// Nothing is shown while in reset
	assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result valid during reset");

	// The rest of a run is already queued when an unmarked beat goes
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !result.last_in_run |=> result_valid)
		else $error("run broken after an unmarked beat");

	// Within a run the row stays or moves on by one
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !result.last_in_run |=>
		(result.out_row == $past(result.out_row)) ||
		(result.out_row == ROW_W'($past(result.out_row) + 1'b1)))
		else $error("row jump within one run");

endmodule

bind gray_box_mean_filter_3x3 gbmf_checker u_gbmf_checker (.*);

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import gbmf_pkg::*;

	localparam int SETTLE_CYCLES  = 8;
	localparam int END_CYCLES     = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_GAP        = 10;

	// Indices past the register list; a write there changes nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] reg_data;
		pixel_t                px;
		logic                  typed;    // results listed in typed_results
		logic [1:0]            n_typed;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  pixel_valid;
	logic                  pixel_ready;
	pixel_t                pixel;
	logic                  result_valid;
	logic                  result_ready;
	result_t               result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Directed part: reset state, a flat white 3x3 frame, then mixed channels
	// with an unused-index write in the middle of the frame
	dir_row_t directed_rows [23] = '{
		'{ROW_PIXEL, REG_WIDTH,  13'd0,    '{8'd0,   8'd0,   8'd0},   1'b1, 2'd0},
		'{ROW_PIXEL, REG_WIDTH,  13'd0,    '{8'd255, 8'd255, 8'd255}, 1'b1, 2'd0},
		'{ROW_WRITE, REG_WIDTH,  13'd3,    '{8'd0,   8'd0,   8'd0},   1'b0, 2'd0},
		'{ROW_WRITE, REG_HEIGHT, 13'd3,    '{8'd0,   8'd0,   8'd0},   1'b0, 2'd0},
		'{ROW_PIXEL, REG_WIDTH,  13'd0,    '{8'd255, 8'd255, 8'd255}, 1'b1, 2'd0},
		'{ROW_PIXEL, REG_WIDTH,  13'd0,    '{8'd255, 8'd255, 8'd255}, 1'b1, 2'd0},
		'{ROW_PIXEL, REG_WIDTH,  13'd0,    '{8'd255, 8'd255, 8'd255}, 1'b1, 2'd0},
		'{ROW_PIXEL, REG_WIDTH,  13'd0,    '{8'd255, 8'd255, 8'd255}, 1'b1, 2'd0},
		'{ROW_PIXEL, REG_WIDTH,  13'd0,    '{8'd255, 8'd255, 8'd255}, 1'b1, 2'd1},
		'{ROW_PIXEL, REG_WIDTH,  13'd0,    '{8'd255, 8'd255, 8'd255}, 1'b1, 2'd2},
		'{ROW_PIXEL, REG_WIDTH,  13'd0,    '{8'd255, 8'd255, 8'd255}, 1'b1, 2'd1},
		'{ROW_PIXEL, REG_WIDTH,  13'd0,    '{8'd255, 8'd255, 8'd255}, 1'b1, 2'd2},
		'{ROW_PIXEL, REG_WIDTH,  13'd0,    '{8'd255, 8'd255, 8'd255}, 1'b1, 2'd3},
		'{ROW_PIXEL, REG_WIDTH,  13'd0,    '{8'd255, 8'd0,   8'd0},   1'b0, 2'd0},
		'{ROW_PIXEL, REG_WIDTH,  13'd0,    '{8'd0,   8'd255, 8'd0},   1'b0, 2'd0},
		'{ROW_PIXEL, REG_WIDTH,  13'd0,    '{8'd0,   8'd0,   8'd255}, 1'b0, 2'd0},
		'{ROW_PIXEL, REG_WIDTH,  13'd0,    '{8'd255, 8'd255, 8'd254}, 1'b0, 2'd0},
		'{ROW_WRITE, REG_UNUSED, 13'h1FFF, '{8'd0,   8'd0,   8'd0},   1'b0, 2'd0},
		'{ROW_PIXEL, REG_WIDTH,  13'd0,    '{8'd1,   8'd1,   8'd0},   1'b0, 2'd0},
		'{ROW_PIXEL, REG_WIDTH,  13'd0,    '{8'd128, 8'd64,  8'd32},  1'b0, 2'd0},
		'{ROW_PIXEL, REG_WIDTH,  13'd0,    '{8'd0,   8'd0,   8'd0},   1'b0, 2'd0},
		'{ROW_PIXEL, REG_WIDTH,  13'd0,    '{8'd170, 8'd85,  8'd42},  1'b0, 2'd0},
		'{ROW_PIXEL, REG_WIDTH,  13'd0,    '{8'd254, 8'd254, 8'd255}, 1'b0, 2'd0}
	};

	// White frame: every result is 255, in release order
	result_t typed_results [9] = '{
		'{11'd0, 12'd0, 8'd255, 1'b1},
		'{11'd1, 12'd0, 8'd255, 1'b0},
		'{11'd2, 12'd0, 8'd255, 1'b1},
		'{11'd0, 12'd2, 8'd255, 1'b1},
		'{11'd0, 12'd1, 8'd255, 1'b0},
		'{11'd1, 12'd2, 8'd255, 1'b1},
		'{11'd1, 12'd1, 8'd255, 1'b0},
		'{11'd2, 12'd1, 8'd255, 1'b0},
		'{11'd2, 12'd2, 8'd255, 1'b1}
	};
	int typed_next;

	// Filter state as the stream sees it
	logic [PIX_W-1:0] gray_line1 [MAX_WIDTH];
	logic [PIX_W-1:0] gray_line2 [MAX_WIDTH];
	logic [PIX_W-1:0] gray_win [6];
	int unsigned      next_col;
	int unsigned      next_row;
	logic [11:0]      width_reg;
	logic [12:0]      height_reg;

	result_t released [3];
	int      released_count;
	result_t awaited_results [$];

	bit calm;
	int error_count;

	gray_box_mean_filter_3x3 uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void add_release(int unsigned col, int unsigned row, int unsigned val);
		released[released_count] = '{COL_W'(col), ROW_W'(row), PIX_W'(val), 1'b0};
		released_count++;
	endfunction

	// One pixel through the filter: fills released[] and moves the window on
	task automatic filter_pixel(input pixel_t px);
		int unsigned w, h, c, r, g, top, mid, sum, val;
		w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
		h = (height_reg < 3) ? 3 : (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;
		c = next_col;
		r = next_row;
		g = (int'(px.red) + int'(px.green) + int'(px.blue)) / 3;
		top = 32'(gray_line2[c]);
		mid = 32'(gray_line1[c]);
		released_count = 0;

		// pixel up-left now has its full neighbourhood
		if (r >= 1 && c >= 1) begin
			if (c >= 2 && r >= 2) begin
				sum = top + mid + g;
				for (int i = 0; i < 6; i++)
					sum += 32'(gray_win[i]);
				val = sum / 9;
			end else begin
				val = 32'(gray_win[1]);
			end
			add_release(c - 1, r - 1, val);
		end
		// right-hand border pixel of the row above
		if (r >= 1 && c + 1 == w)
			add_release(c, r - 1, mid);
		// bottom row passes straight through
		if (r + 1 == h)
			add_release(c, r, g);
		if (released_count > 0)
			released[released_count - 1].last_in_run = 1'b1;

		gray_line2[c] = PIX_W'(mid);
		gray_line1[c] = PIX_W'(g);
		gray_win[3] = gray_win[0];
		gray_win[4] = gray_win[1];
		gray_win[5] = gray_win[2];
		gray_win[0] = PIX_W'(top);
		gray_win[1] = PIX_W'(mid);
		gray_win[2] = PIX_W'(g);

		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		next_col = c;
		next_row = r;
	endtask

	// Holds the pixel side until every awaited result has come back
	task automatic wait_drained();
		pixel_valid <= 1'b0;
		do
			@(posedge clk);
		while (awaited_results.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		wait_drained();
		// a pixel that releases nothing may still be in the pipeline
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WIDTH)
			width_reg = data[11:0];
		if (idx == REG_HEIGHT)
			height_reg = data;
		// either register restarts the frame
		if (idx == REG_WIDTH || idx == REG_HEIGHT) begin
			gray_win = '{default: '0};
			next_col = 0;
			next_row = 0;
		end
	endtask

	task automatic send_pixel(input pixel_t px, input logic typed, input int n_typed);
		int gap;
		gap = calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel       <= px;
		@(posedge clk);
		while (pixel_ready !== 1'b1)
			@(posedge clk);
		// beat taken at this edge
		filter_pixel(px);
		if (typed) begin
			repeat (n_typed) begin
				awaited_results.push_back(typed_results[typed_next]);
				typed_next++;
			end
		end else begin
			for (int k = 0; k < released_count; k++)
				awaited_results.push_back(released[k]);
		end
	endtask

	task automatic feed_pixels(input int count);
		logic [23:0] bits;
		int          pick;
		for (int k = 0; k < count; k++) begin
			if (!calm && (k == count / 2 || $urandom_range(0, 39) == 0))
				wait_drained();
			// lean towards flat black and white for the mean extremes
			pick = $urandom_range(0, 9);
			if (pick == 0)
				bits = '1;
			else if (pick == 1)
				bits = '0;
			else
				bits = 24'($urandom);
			send_pixel(bits, 1'b0, 0);
		end
	endtask

	// Result side: random stalls, compare each beat with the oldest expectation
	initial begin
		int      stall;
		result_t want;
		result_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (result_valid !== 1'b1)
				@(posedge clk);
			if (awaited_results.size() == 0) begin
				$error("result beat with nothing awaited: col %0d row %0d filtered %0d",
					result.out_col, result.out_row, result.filtered);
				error_count++;
			end else begin
				want = awaited_results.pop_front();
				if (result.out_col !== want.out_col) begin
					$error("out_col: expected %0d, actual %0d", want.out_col, result.out_col);
					error_count++;
				end
				if (result.out_row !== want.out_row) begin
					$error("out_row: expected %0d, actual %0d", want.out_row, result.out_row);
					error_count++;
				end
				if (result.filtered !== want.filtered) begin
					$error("filtered: expected %0d, actual %0d", want.filtered, result.filtered);
					error_count++;
				end
				if (result.last_in_run !== want.last_in_run) begin
					$error("last_in_run: expected %0d, actual %0d",
						want.last_in_run, result.last_in_run);
					error_count++;
				end
			end
		end
	end

	// Watchdog: too long without any beat or register write
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n === 1'b1);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((pixel_valid && pixel_ready) || (result_valid && result_ready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n      <= 1'b0;
		pixel_valid <= 1'b0;
		pixel       <= '0;
		cfg_we      <= 1'b0;
		cfg_index   <= REG_WIDTH;
		cfg_data    <= '0;
		calm        = 1'b0;
		error_count = 0;
		typed_next  = 0;
		width_reg   = 12'd640;
		height_reg  = 13'd480;
		next_col    = 0;
		next_row    = 0;
		gray_win    = '{default: '0};
		foreach (gray_line1[i]) begin
			gray_line1[i] = '0;
			gray_line2[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE)
				write_reg(directed_rows[i].reg_index, directed_rows[i].reg_data);
			else
				send_pixel(directed_rows[i].px, directed_rows[i].typed,
					directed_rows[i].n_typed);
		end

		// small frames of random geometry
		repeat (3) begin
			write_reg(REG_WIDTH, 13'($urandom_range(3, 5)));
			write_reg(REG_HEIGHT, 13'($urandom_range(3, 4)));
			feed_pixels($urandom_range(9, 16));
		end

		// out-of-range values, masked width bit, an unused index mid-frame
		write_reg(REG_WIDTH, 13'd0);
		write_reg(REG_HEIGHT, 13'd1);
		feed_pixels(10);
		write_reg(REG_WIDTH, 13'h1004);
		write_reg(REG_HEIGHT, 13'd2);
		feed_pixels(5);
		write_reg($urandom_range(0, 1) ? REG_SPARE : REG_UNUSED, 13'($urandom));
		feed_pixels(5);
		write_reg(REG_HEIGHT, 13'd5);
		feed_pixels(8);
		write_reg(REG_WIDTH, 13'd2);
		feed_pixels(6);

		// largest geometries, streamed back to back
		calm = 1'b1;
		write_reg(REG_WIDTH, 13'd2048);
		write_reg(REG_HEIGHT, 13'd3);
		feed_pixels(5);
		write_reg(REG_WIDTH, 13'd4095);
		feed_pixels(4);
		write_reg(REG_WIDTH, 13'd3);
		write_reg(REG_HEIGHT, 13'd4096);
		feed_pixels(5);
		write_reg(REG_HEIGHT, 13'h1FFF);
		feed_pixels(4);
		calm = 1'b0;

		write_reg(REG_WIDTH, 13'd4);
		write_reg(REG_HEIGHT, 13'd3);
		feed_pixels(14);

		wait_drained();
		repeat (END_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
